// File: sv/spp_pkg.sv
// Package for the spectral peak picker: payload structs, internal stage structs,
// register map codes and sizing constants. No dependencies.
package spp_pkg;

  localparam int unsigned MaxBins    = 4096;
  localparam int unsigned BinCntW    = $clog2(MaxBins);
  localparam int unsigned PeakBinW   = 12;
  localparam int unsigned PowerW     = 32;
  localparam int unsigned HzW        = 32;
  localparam int unsigned PeakHzW    = 44;
  localparam int unsigned MaxPeaksW  = 12;
  localparam int unsigned SampleW    = 16;

  localparam int unsigned OqDepth    = 8;
  localparam int unsigned OqPtrW     = $clog2(OqDepth);
  localparam int unsigned OqCntW     = $clog2(OqDepth + 1);

  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic RegMaxPeaks = 1'b0;
  localparam logic RegHzPerBin = 1'b1;

  localparam logic [MaxPeaksW-1:0] MaxPeaksReset = MaxPeaksW'(8);
  localparam logic [HzW-1:0]       HzPerBinReset = HzW'(5644800);

  typedef struct packed {
    logic signed [SampleW-1:0] real_part;
    logic signed [SampleW-1:0] imag_part;
    logic                      frame_end;
  } in_item_t;

  typedef struct packed {
    logic [PeakBinW-1:0] peak_bin;
    logic [PowerW-1:0]   peak_power;
    logic [PeakHzW-1:0]  peak_hz;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [PowerW-1:0] power;
    logic              frame_end;
  } pwr_t;

  typedef struct packed {
    logic                valid;
    logic                emit;
    logic [PeakBinW-1:0] bin;
    logic [PowerW-1:0]   power;
  } cand_t;

endpackage

// File: sv/spp_regs.sv
// Configuration register file of the spectral peak picker behind an APB-style port.
// Depends on spp_pkg.
module spp_regs
  import spp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready,
  output logic [MaxPeaksW-1:0] max_peaks_o,
  output logic [HzW-1:0]       hz_per_bin_o
);

  logic [MaxPeaksW-1:0] max_peaks_q, max_peaks_d;
  logic [HzW-1:0]       hz_per_bin_q, hz_per_bin_d;
  logic                 wr_en;
  logic                 reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    max_peaks_d  = max_peaks_q;
    hz_per_bin_d = hz_per_bin_q;
    if (wr_en) begin
      case (reg_sel)
        RegMaxPeaks: max_peaks_d  = pwdata[MaxPeaksW-1:0];
        RegHzPerBin: hz_per_bin_d = pwdata[HzW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegMaxPeaks: prdata = ApbDataW'(max_peaks_q);
      RegHzPerBin: prdata = ApbDataW'(hz_per_bin_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_peaks_q  <= MaxPeaksReset;
      hz_per_bin_q <= HzPerBinReset;
    end else begin
      max_peaks_q  <= max_peaks_d;
      hz_per_bin_q <= hz_per_bin_d;
    end
  end

  assign max_peaks_o  = max_peaks_q;
  assign hz_per_bin_o = hz_per_bin_q;

endmodule

// File: sv/spp_power.sv
// Input register and power stage: registers each bin, then forms re*re + im*im.
// Depends on spp_pkg.
module spp_power
  import spp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output pwr_t     pwr_o
);

  in_item_t           item_q;
  logic               valid_q;
  pwr_t               pwr_q, pwr_d;
  logic signed [31:0] re_sq;
  logic signed [31:0] im_sq;

  assign re_sq = item_q.real_part * item_q.real_part;
  assign im_sq = item_q.imag_part * item_q.imag_part;

  always_comb begin
    pwr_d.valid     = valid_q;
    pwr_d.power     = PowerW'({1'b0, re_sq[30:0]}) + PowerW'({1'b0, im_sq[30:0]});
    pwr_d.frame_end = item_q.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pwr_q   <= '0;
    end else begin
      valid_q <= accept_i;
      pwr_q   <= pwr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
  end

  assign pwr_o = pwr_q;

endmodule

// File: sv/spp_detect.sv
// Peak detector: holds the two previous powers and the frame counters, and marks
// the centre bin as a peak when it beats both neighbours. Depends on spp_pkg.
module spp_detect
  import spp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pwr_t                 pwr_i,
  input  logic [MaxPeaksW-1:0] max_peaks_i,
  output cand_t                cand_o
);

  logic [PowerW-1:0]    left_q, left_d;
  logic [PowerW-1:0]    centre_q, centre_d;
  logic [BinCntW-1:0]   bins_q, bins_d;
  logic [MaxPeaksW-1:0] peaks_q, peaks_d;
  cand_t                cand_q, cand_d;
  logic                 is_peak;
  logic [BinCntW-1:0]   idx;

  assign idx     = bins_q - BinCntW'(1);
  assign is_peak = (bins_q >= BinCntW'(2)) && (left_q < centre_q) &&
                   (pwr_i.power < centre_q) && (peaks_q < max_peaks_i);

  always_comb begin
    left_d   = left_q;
    centre_d = centre_q;
    bins_d   = bins_q;
    peaks_d  = peaks_q;
    cand_d.valid = pwr_i.valid;
    cand_d.emit  = pwr_i.valid & is_peak;
    cand_d.bin   = PeakBinW'(idx);
    cand_d.power = centre_q;
    if (pwr_i.valid) begin
      if (pwr_i.frame_end) begin
        left_d   = '0;
        centre_d = '0;
        bins_d   = '0;
        peaks_d  = '0;
      end else begin
        left_d   = centre_q;
        centre_d = pwr_i.power;
        if (bins_q != BinCntW'(MaxBins - 1)) begin
          bins_d = bins_q + BinCntW'(1);
        end
        if (is_peak) begin
          peaks_d = peaks_q + MaxPeaksW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      centre_q <= '0;
      bins_q   <= '0;
      peaks_q  <= '0;
      cand_q   <= '0;
    end else begin
      left_q   <= left_d;
      centre_q <= centre_d;
      bins_q   <= bins_d;
      peaks_q  <= peaks_d;
      cand_q   <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

// File: sv/spp_outq.sv
// Frequency multiply and output queue with credit count for the input stall.
// Depends on spp_pkg.
module spp_outq
  import spp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_accept_i,
  input  cand_t          cand_i,
  input  logic [HzW-1:0] hz_per_bin_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output out_item_t      out_item_o
);

  out_item_t           mem_q [OqDepth];
  logic [OqPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OqPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OqCntW-1:0]   count_q, count_d;
  logic [OqCntW-1:0]   pending_q, pending_d;
  logic                push;
  logic                pop;
  logic                drop;
  logic [PeakHzW-1:0]  hz;
  out_item_t           wr_item;

  assign hz   = cand_i.bin * hz_per_bin_i;
  assign push = cand_i.valid & cand_i.emit;
  assign drop = cand_i.valid & ~cand_i.emit;
  assign pop  = out_valid_o & ~out_stall_i;

  always_comb begin
    wr_item.peak_bin   = cand_i.bin;
    wr_item.peak_power = cand_i.power;
    wr_item.peak_hz    = hz;
  end

  always_comb begin
    wr_ptr_d  = push ? wr_ptr_q + OqPtrW'(1) : wr_ptr_q;
    rd_ptr_d  = pop ? rd_ptr_q + OqPtrW'(1) : rd_ptr_q;
    count_d   = count_q + OqCntW'(push) - OqCntW'(pop);
    pending_d = pending_q + OqCntW'(in_accept_i) - OqCntW'(drop) - OqCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      count_q   <= '0;
      pending_q <= '0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      count_q   <= count_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item;
    end
  end

  assign full_o      = (pending_q >= OqCntW'(OqDepth));
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];

endmodule

// File: sv/spectral_peak_picker.sv
// Top level of the spectral peak picker: register port, power stage, detector and
// output queue. Depends on spp_pkg, spp_regs, spp_power, spp_detect and spp_outq.
//
// The block takes one spectrum bin per clock cycle and reports three-point local
// maxima of the power re*re + im*im, each with its bin index, power and frequency
// in Q28.16 hertz. A peak is reported when the bin after it arrives, so a result
// follows its right neighbour through the input register, power stage, detector
// and output queue. Sustained rate is one bin per cycle while in_stall_o is low.
// An eight-entry output queue with a credit count drives in_stall_o, so input is
// held off only once eight transactions are in flight or waiting at the output. A
// bin with frame_end set closes the frame and clears the detector state; at most
// max_peaks peaks are reported per frame. Registers: max_peaks at byte address 0,
// hz_per_bin at byte address 4; write them only while the block is idle.
module spectral_peak_picker
  import spp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o
);

  logic [MaxPeaksW-1:0] max_peaks;
  logic [HzW-1:0]       hz_per_bin;
  logic                 in_accept;
  logic                 full;
  pwr_t                 pwr;
  cand_t                cand;

  assign in_stall_o = full;
  assign in_accept  = in_valid_i & ~full;

  spp_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_peaks_o  (max_peaks),
    .hz_per_bin_o (hz_per_bin)
  );

  spp_power u_power (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_item_i),
    .pwr_o    (pwr)
  );

  spp_detect u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pwr_i       (pwr),
    .max_peaks_i (max_peaks),
    .cand_o      (cand)
  );

  spp_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .cand_i       (cand),
    .hz_per_bin_i (hz_per_bin),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for spectral_peak_picker: predicts every reported peak from the
// accepted bins and the register settings, and checks each result as it arrives.
// Depends on spp_pkg and the spectral_peak_picker RTL.
module tb;
  import spp_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned LongHold    = 80;

  typedef enum int {FullRange, TinyValues, Ridges} frame_style_e;

  class peak_predictor;
    logic [MaxPeaksW-1:0] max_peaks;
    logic [HzW-1:0]       hz_per_bin;
    logic [PowerW-1:0]    left_power;
    logic [PowerW-1:0]    centre_power;
    logic [BinCntW-1:0]   bins_seen;
    logic [BinCntW-1:0]   peaks_emitted;
    out_item_t            peaks_due[$];
    int unsigned          mismatches;

    function new();
      max_peaks  = MaxPeaksReset;
      hz_per_bin = HzPerBinReset;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      left_power    = '0;
      centre_power  = '0;
      bins_seen     = '0;
      peaks_emitted = '0;
    endfunction

    function void set_register(logic reg_idx, logic [ApbDataW-1:0] value);
      if (reg_idx == RegMaxPeaks) begin
        max_peaks = value[MaxPeaksW-1:0];
      end else begin
        hz_per_bin = value[HzW-1:0];
      end
    endfunction

    function logic [ApbDataW-1:0] register_value(logic reg_idx);
      if (reg_idx == RegMaxPeaks) begin
        return ApbDataW'(max_peaks);
      end
      return ApbDataW'(hz_per_bin);
    endfunction

    function logic [PowerW-1:0] bin_power(logic signed [SampleW-1:0] re,
                                          logic signed [SampleW-1:0] im);
      longint a;
      longint b;
      a = re;
      b = im;
      a = (a < 0) ? -a : a;
      b = (b < 0) ? -b : b;
      return PowerW'(a * a + b * b);
    endfunction

    function void take_bin(in_item_t bin);
      logic [PowerW-1:0]   power;
      logic [PeakBinW-1:0] idx;
      out_item_t           peak;
      power = bin_power(bin.real_part, bin.imag_part);
      if (bins_seen >= 2 && left_power < centre_power && power < centre_power &&
          peaks_emitted < max_peaks) begin
        idx             = PeakBinW'(bins_seen - 1);
        peak.peak_bin   = idx;
        peak.peak_power = centre_power;
        peak.peak_hz    = PeakHzW'(idx) * PeakHzW'(hz_per_bin);
        peaks_due.push_back(peak);
        peaks_emitted++;
      end
      left_power   = centre_power;
      centre_power = power;
      if (bins_seen < MaxBins - 1) begin
        bins_seen++;
      end
      if (bin.frame_end) begin
        clear_frame();
      end
    endfunction

    function void match_peak(out_item_t got);
      out_item_t want;
      if (peaks_due.size() == 0) begin
        $error("unexpected peak: bin %0d, power %0d, hz %0d",
               got.peak_bin, got.peak_power, got.peak_hz);
        mismatches++;
        return;
      end
      want = peaks_due.pop_front();
      if (got.peak_bin !== want.peak_bin) begin
        $error("peak_bin: expected %0d, got %0d", want.peak_bin, got.peak_bin);
        mismatches++;
      end
      if (got.peak_power !== want.peak_power) begin
        $error("peak_power: expected %0d, got %0d", want.peak_power, got.peak_power);
        mismatches++;
      end
      if (got.peak_hz !== want.peak_hz) begin
        $error("peak_hz: expected %0d, got %0d", want.peak_hz, got.peak_hz);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_item_o;

  peak_predictor peaks;
  int unsigned   cycle_count = 0;
  int unsigned   hold_asks = 0;
  bit            gap_free = 1'b0;

  spectral_peak_picker dut (.*);

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("spectral_peak_picker regression: fail");
      $finish;
    end
  end

  task automatic read_back(logic reg_idx);
    logic [ApbDataW-1:0] want;
    want = peaks.register_value(reg_idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrW'(4 * reg_idx);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $error("register %0d: expected %0d, got %0d", reg_idx, want, prdata);
      peaks.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_register(logic reg_idx, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * reg_idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    peaks.set_register(reg_idx, value);
    @(posedge clk_i);
    read_back(reg_idx);
  endtask

  task automatic send_bin(logic signed [SampleW-1:0] re, logic signed [SampleW-1:0] im,
                          logic last);
    in_item_t    bin;
    int unsigned gap;
    int unsigned pick;
    bin.real_part = re;
    bin.imag_part = im;
    bin.frame_end = last;
    in_valid_i <= 1'b1;
    in_item_i  <= bin;
    do @(posedge clk_i); while (in_stall_o);
    peaks.take_bin(bin);
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (!gap_free && pick >= 70) begin
      gap = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (peaks.peaks_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_frame(int unsigned len, frame_style_e style);
    int re;
    int im;
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        FullRange: begin
          re = $urandom_range(0, 65535);
          im = $urandom_range(0, 65535);
        end
        TinyValues: begin
          re = int'($urandom_range(0, 4)) - 2;
          im = int'($urandom_range(0, 4)) - 2;
        end
        default: begin
          re = (i % 2) ? $urandom_range(1000, 32767) : $urandom_range(0, 300);
          im = $urandom_range(0, 300);
          if ($urandom_range(0, 1)) re = -re;
          if ($urandom_range(0, 1)) im = -im;
        end
      endcase
      send_bin(SampleW'(re), SampleW'(im), i == len - 1);
    end
  endtask

  initial begin
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned hold_seen;
    int unsigned pick;
    stall_left  = 0;
    free_left   = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        peaks.match_peak(out_item_o);
      end
      if (hold_seen != hold_asks) begin
        hold_seen  = hold_asks;
        stall_left = LongHold;
      end
      if (stall_left == 0 && free_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          free_left = $urandom_range(1, 40);
        end else if (pick < 93) begin
          stall_left = $urandom_range(1, 3);
        end else begin
          stall_left = $urandom_range(10, 40);
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        free_left--;
      end
    end
  end

  initial begin
    int unsigned  sent;
    int unsigned  len;
    int unsigned  pick;
    logic [31:0]  hz;
    logic [11:0]  most;
    peaks      = new();
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_back(RegMaxPeaks);
    read_back(RegHzPerBin);

    // One-bin and two-bin frames, the largest power, ties, and a peak closed by frame_end.
    send_bin(16'sd32767, 16'sd32767, 1'b1);
    send_bin(16'sh8000, 16'sd0, 1'b0);
    send_bin(16'sd0, 16'sh8000, 1'b1);
    send_bin(16'sd0, 16'sd0, 1'b0);
    send_bin(16'sh8000, 16'sh8000, 1'b0);
    send_bin(16'sd0, 16'sd0, 1'b0);
    send_bin(16'sd7, -16'sd7, 1'b0);
    send_bin(-16'sd7, 16'sd7, 1'b0);
    send_bin(16'sd1, 16'sd0, 1'b0);
    send_bin(16'sd32767, 16'sh8000, 1'b0);
    send_bin(16'sd0, 16'sd1, 1'b1);
    wait_drained();

    write_register(RegMaxPeaks, 32'd1);
    write_register(RegHzPerBin, 32'd0);
    send_frame(8, Ridges);
    wait_drained();

    write_register(RegMaxPeaks, 32'd0);
    write_register(RegHzPerBin, 32'hFFFF_FFFF);
    send_frame(6, Ridges);
    wait_drained();

    for (int unsigned phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin most = 12'd2;                        hz = $urandom(); end
        1: begin most = 12'd4095;                     hz = 32'hFFFF_FFFF; end
        2: begin most = 12'd4095;                     hz = 32'd0; end
        3: begin most = 12'($urandom_range(0, 4095)); hz = $urandom(); end
        4: begin most = 12'd8;                        hz = HzPerBinReset; end
        default: begin most = 12'($urandom_range(1, 20)); hz = $urandom(); end
      endcase
      write_register(RegMaxPeaks, 32'(most));
      write_register(RegHzPerBin, hz);
      sent = 0;
      if (phase == 2) begin
        hold_asks++;
        gap_free = 1'b1;
        send_frame(60, Ridges);
        sent = 60;
      end
      while (sent < 100) begin
        gap_free = ($urandom_range(0, 3) == 0);
        pick     = $urandom_range(0, 99);
        if (pick < 10) begin
          len = $urandom_range(1, 2);
        end else if (pick < 95) begin
          len = $urandom_range(3, 40);
        end else begin
          len = $urandom_range(41, 120);
        end
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          send_frame(len, FullRange);
        end else if (pick < 50) begin
          send_frame(len, TinyValues);
        end else begin
          send_frame(len, Ridges);
        end
        sent += len;
      end
      wait_drained();
    end

    if (peaks.mismatches == 0 && peaks.peaks_due.size() == 0) begin
      $display("spectral_peak_picker regression: pass");
    end else begin
      $display("spectral_peak_picker regression: fail");
    end
    $finish;
  end

endmodule
